// ===== src/tms_pkg.sv =====
// ----------------------------------------------------------------------------
// tms_pkg
// shared types, codes and sizes for the turing machine stepper
// ----------------------------------------------------------------------------
package tms_pkg;

  localparam int STATE_BITS  = 6;
  localparam int SYMBOL_BITS = 4;
  localparam int HEAD_BITS   = 12;
  localparam int TAPE_CELLS  = 4096;
  localparam int TAPE_AW     = $clog2(TAPE_CELLS);
  localparam int TABLE_AW    = STATE_BITS + SYMBOL_BITS;
  localparam int TABLE_DEPTH = 1 << TABLE_AW;
  localparam int CFG_DW      = 12;
  localparam int CFG_IW      = 3;
  localparam int CLR_DEPTH   = (TAPE_CELLS > TABLE_DEPTH) ? TAPE_CELLS : TABLE_DEPTH;
  localparam int CLR_W       = $clog2(CLR_DEPTH);

  localparam logic [HEAD_BITS-1:0] START_HEAD_RST = HEAD_BITS'(2048);

  typedef enum logic [2:0] {
    KIND_TABLE_WR = 3'd0,
    KIND_TAPE_WR  = 3'd1,
    KIND_START    = 3'd2,
    KIND_STEP     = 3'd3,
    KIND_TAPE_RD  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HALTED   = 3'd1,
    ST_NO_ENTRY = 3'd2,
    ST_BAD_MOVE = 3'd3,
    ST_OFF_TAPE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MOVE_LEFT  = 2'd0,
    MOVE_RIGHT = 2'd1,
    MOVE_STAY  = 2'd2,
    MOVE_BAD   = 2'd3
  } move_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_START_STATE = 3'd0,
    CFG_START_HEAD  = 3'd1,
    CFG_HALT_STATE  = 3'd2,
    CFG_NOP_STATE   = 3'd3,
    CFG_BLANK       = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_READ,
    FSM_TAPE,
    FSM_TABLE
  } fsm_e;

  typedef struct packed {
    logic [2:0]             kind;
    logic [STATE_BITS-1:0]  state_in;
    logic [SYMBOL_BITS-1:0] symbol_in;
    logic [SYMBOL_BITS-1:0] write_symbol;
    logic [1:0]             move_code;
    logic [STATE_BITS-1:0]  next_state;
    logic [HEAD_BITS-1:0]   position;
  } item_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [STATE_BITS-1:0]  state_out;
    logic [HEAD_BITS-1:0]   head_out;
    logic [SYMBOL_BITS-1:0] symbol_out;
    logic                   halted;
  } result_t;

  typedef struct packed {
    logic                   written;
    logic [SYMBOL_BITS-1:0] sym;
  } tape_word_t;

  typedef struct packed {
    logic                   present;
    logic [SYMBOL_BITS-1:0] sym;
    logic [1:0]             move;
    logic [STATE_BITS-1:0]  next;
  } table_word_t;

endpackage

// ===== src/turing_machine_stepper.sv =====
// ----------------------------------------------------------------------------
// turing_machine_stepper
// single-tape turing machine with a loadable transition table
// ----------------------------------------------------------------------------
// usage
//   an item transfers at a clock edge with start high and busy low; item_i
//   carries the kind and its operands. every item gives one result, shown on
//   result_o for one cycle while result_valid_o is high; the receiver cannot
//   hold it off, so nothing ever waits on the output side.
//   configuration registers are written via cfg_we_i/cfg_index_i/cfg_wdata_i,
//   by the user only while the block is idle; the block does not enforce it.
// item handling
//   table write, tape write, start and unknown kinds: result in the cycle
//   after the transfer, and the next item may follow at once
//   tape read: tape ram read then result register, next item waits on busy
//   step: tape read, then table read keyed by state and cell, then tape
//   write-back, result registered, next item waits on busy. a step refused
//   for a halted machine or a head off the tape answers like a table write
// reset
//   state and head registers clear, configuration takes its reset values,
//   then a clearing pass wipes the written flags of the tape and the present
//   flags of the table; busy stays high throughout
// ----------------------------------------------------------------------------
module turing_machine_stepper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  tms_pkg::item_t                 item_i,
  input  logic                           cfg_we_i,
  input  logic [tms_pkg::CFG_IW-1:0]     cfg_index_i,
  input  logic [tms_pkg::CFG_DW-1:0]     cfg_wdata_i,
  output logic                           result_valid_o,
  output tms_pkg::result_t               result_o
);

  import tms_pkg::*;

  // control and machine registers
  fsm_e                   fsm_q, fsm_d;
  logic [CLR_W-1:0]       clr_q, clr_d;
  logic [STATE_BITS-1:0]  state_q, state_d;
  logic [HEAD_BITS-1:0]   head_q, head_d;
  result_t                result_q, result_d;
  logic                   result_valid_q, result_valid_d;

  // configuration
  logic [STATE_BITS-1:0]  start_state_q;
  logic [HEAD_BITS-1:0]   start_head_q;
  logic [STATE_BITS-1:0]  halt_state_q;
  logic [STATE_BITS-1:0]  nop_state_q;
  logic [SYMBOL_BITS-1:0] blank_q;

  // memory ports
  logic                   tape_we;
  logic [TAPE_AW-1:0]     tape_addr;
  tape_word_t             tape_wdata, tape_rdata;
  logic                   tab_we;
  logic [TABLE_AW-1:0]    tab_addr;
  table_word_t            tab_wdata, tab_rdata;

  // result assembly
  logic                   emit;
  status_e                status;
  logic [SYMBOL_BITS-1:0] sym_out;
  logic [SYMBOL_BITS-1:0] cell_sym;
  logic                   pos_ok;
  logic                   head_ok;
  logic                   right_edge;

  // tape cells with their written flag
  tms_ram #(
    .WIDTH ($bits(tape_word_t)),
    .DEPTH (TAPE_CELLS)
  ) u_tape (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .addr_i  (tape_addr),
    .wdata_i (tape_wdata),
    .rdata_o (tape_rdata)
  );

  // transition table with its present flag
  tms_ram #(
    .WIDTH ($bits(table_word_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .addr_i  (tab_addr),
    .wdata_i (tab_wdata),
    .rdata_o (tab_rdata)
  );

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_state_q <= '0;
      start_head_q  <= START_HEAD_RST;
      halt_state_q  <= STATE_BITS'(63);
      nop_state_q   <= STATE_BITS'(62);
      blank_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START_STATE: start_state_q <= cfg_wdata_i[STATE_BITS-1:0];
        CFG_START_HEAD:  start_head_q  <= cfg_wdata_i[HEAD_BITS-1:0];
        CFG_HALT_STATE:  halt_state_q  <= cfg_wdata_i[STATE_BITS-1:0];
        CFG_NOP_STATE:   nop_state_q   <= cfg_wdata_i[STATE_BITS-1:0];
        CFG_BLANK:       blank_q       <= cfg_wdata_i[SYMBOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q          <= FSM_CLEAR;
      clr_q          <= '0;
      state_q        <= '0;
      head_q         <= '0;
      result_valid_q <= 1'b0;
    end else begin
      fsm_q          <= fsm_d;
      clr_q          <= clr_d;
      state_q        <= state_d;
      head_q         <= head_d;
      result_valid_q <= result_valid_d;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  // range checks on the head and the item position
  assign pos_ok     = (32'(item_i.position) < TAPE_CELLS);
  assign head_ok    = (32'(head_q) < TAPE_CELLS);
  assign right_edge = ((32'(head_q) + 32'd1) >= TAPE_CELLS);

  // cell seen through the written flag
  assign cell_sym = tape_rdata.written ? tape_rdata.sym : blank_q;

  always_comb begin
    fsm_d          = fsm_q;
    clr_d          = clr_q;
    state_d        = state_q;
    head_d         = head_q;
    result_valid_d = 1'b0;
    emit           = 1'b0;
    status         = ST_OK;
    sym_out        = '0;

    tape_we        = 1'b0;
    tape_addr      = TAPE_AW'(head_q);
    tape_wdata     = '0;
    tab_we         = 1'b0;
    tab_addr       = {state_q, cell_sym};
    tab_wdata      = '0;

    unique case (fsm_q)
      FSM_CLEAR: begin
        // wipe both flags, one entry of each memory per cycle
        tape_we   = 1'b1;
        tape_addr = TAPE_AW'(clr_q);
        tab_we    = 1'b1;
        tab_addr  = TABLE_AW'(clr_q);
        clr_d     = clr_q + CLR_W'(1);
        if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
          fsm_d = FSM_IDLE;
        end
      end

      FSM_IDLE: begin
        if (start) begin
          case (item_i.kind)
            KIND_TABLE_WR: begin
              tab_we    = 1'b1;
              tab_addr  = {item_i.state_in, item_i.symbol_in};
              tab_wdata = '{present: 1'b1, sym: item_i.write_symbol,
                            move: item_i.move_code, next: item_i.next_state};
              emit      = 1'b1;
            end
            KIND_TAPE_WR: begin
              if (pos_ok) begin
                tape_we    = 1'b1;
                tape_addr  = TAPE_AW'(item_i.position);
                tape_wdata = '{written: 1'b1, sym: item_i.symbol_in};
              end else begin
                status = ST_OFF_TAPE;
              end
              emit = 1'b1;
            end
            KIND_START: begin
              state_d = start_state_q;
              head_d  = start_head_q;
              emit    = 1'b1;
            end
            KIND_STEP: begin
              if (state_q == halt_state_q) begin
                status = ST_HALTED;
                emit   = 1'b1;
              end else if (!head_ok) begin
                status = ST_OFF_TAPE;
                emit   = 1'b1;
              end else begin
                // fetch the cell under the head
                fsm_d = FSM_TAPE;
              end
            end
            KIND_TAPE_RD: begin
              if (pos_ok) begin
                tape_addr = TAPE_AW'(item_i.position);
                fsm_d     = FSM_READ;
              end else begin
                status = ST_OFF_TAPE;
                emit   = 1'b1;
              end
            end
            default: begin
              // unknown kinds do nothing
              emit = 1'b1;
            end
          endcase
        end
      end

      FSM_READ: begin
        sym_out = cell_sym;
        emit    = 1'b1;
        fsm_d   = FSM_IDLE;
      end

      FSM_TAPE: begin
        // key the table by current state and the cell symbol
        tab_addr = {state_q, cell_sym};
        fsm_d    = FSM_TABLE;
      end

      FSM_TABLE: begin
        emit  = 1'b1;
        fsm_d = FSM_IDLE;
        if (!tab_rdata.present) begin
          status = ST_NO_ENTRY;
        end else if (tab_rdata.move == MOVE_BAD) begin
          status = ST_BAD_MOVE;
        end else if (tab_rdata.move == MOVE_LEFT && head_q == '0) begin
          status = ST_OFF_TAPE;
        end else if (tab_rdata.move == MOVE_RIGHT && right_edge) begin
          status = ST_OFF_TAPE;
        end else begin
          // write back the cell and commit the move
          tape_we    = 1'b1;
          tape_wdata = '{written: 1'b1, sym: tab_rdata.sym};
          if (tab_rdata.move == MOVE_LEFT) begin
            head_d = head_q - HEAD_BITS'(1);
          end else if (tab_rdata.move == MOVE_RIGHT) begin
            head_d = head_q + HEAD_BITS'(1);
          end
          if (tab_rdata.next != nop_state_q) begin
            state_d = tab_rdata.next;
          end
          sym_out = tab_rdata.sym;
        end
      end

      default: begin
        fsm_d = FSM_IDLE;
      end
    endcase

    result_d = result_q;
    if (emit) begin
      result_valid_d = 1'b1;
      result_d       = '{status: status, state_out: state_d, head_out: head_d,
                         symbol_out: sym_out, halted: (state_d == halt_state_q)};
    end
  end

  assign busy           = (fsm_q != FSM_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// ===== src/tms_ram.sv =====
// ----------------------------------------------------------------------------
// tms_ram
// single-port synchronous ram, one write or read per cycle, registered read
// ----------------------------------------------------------------------------
module tms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== dv/turing_machine_stepper_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// turing_machine_stepper_checker
// watches item, configuration and result transfers of the stepper, keeps its
// own copy of tape, rule table and machine registers, and compares every
// result with the oldest outstanding prediction
// ----------------------------------------------------------------------------
module turing_machine_stepper_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  tms_pkg::item_t                 item_i,
  input  logic                           cfg_we_i,
  input  logic [tms_pkg::CFG_IW-1:0]     cfg_index_i,
  input  logic [tms_pkg::CFG_DW-1:0]     cfg_wdata_i,
  input  logic                           result_valid_i,
  input  tms_pkg::result_t               result_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  import tms_pkg::*;

  tape_word_t             tape_cells [TAPE_CELLS];
  table_word_t            rule_table [TABLE_DEPTH];
  logic [STATE_BITS-1:0]  machine_state;
  logic [HEAD_BITS-1:0]   head_pos;

  logic [STATE_BITS-1:0]  start_state_q;
  logic [HEAD_BITS-1:0]   start_head_q;
  logic [STATE_BITS-1:0]  halt_state_q;
  logic [STATE_BITS-1:0]  nop_state_q;
  logic [SYMBOL_BITS-1:0] blank_q;

  result_t                due_results [$];
  result_t                oldest;

  function void clear_machine();
    for (int i = 0; i < TAPE_CELLS; i++) tape_cells[i] = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) rule_table[i] = '0;
    machine_state = '0;
    head_pos      = '0;
    start_state_q = '0;
    start_head_q  = START_HEAD_RST;
    halt_state_q  = STATE_BITS'(63);
    nop_state_q   = STATE_BITS'(62);
    blank_q       = '0;
  endfunction

  // never-written cells read as the blank symbol
  function automatic logic [SYMBOL_BITS-1:0] cell_symbol(logic [HEAD_BITS-1:0] pos);
    return tape_cells[pos].written ? tape_cells[pos].sym : blank_q;
  endfunction

  function automatic result_t predict_item(item_t it);
    result_t                r;
    table_word_t            rule;
    logic [TABLE_AW-1:0]    key;
    logic [HEAD_BITS-1:0]   new_head;
    r = '0;
    case (it.kind)
      KIND_TABLE_WR: begin
        key = {it.state_in, it.symbol_in};
        rule_table[key] = '{present: 1'b1, sym: it.write_symbol,
                            move: it.move_code, next: it.next_state};
      end
      KIND_TAPE_WR: begin
        if (int'(it.position) < TAPE_CELLS) begin
          tape_cells[it.position] = '{written: 1'b1, sym: it.symbol_in};
        end else begin
          r.status = ST_OFF_TAPE;
        end
      end
      KIND_START: begin
        machine_state = start_state_q;
        head_pos      = start_head_q;
      end
      KIND_STEP: begin
        if (machine_state == halt_state_q) begin
          r.status = ST_HALTED;
        end else if (int'(head_pos) >= TAPE_CELLS) begin
          r.status = ST_OFF_TAPE;
        end else begin
          key  = {machine_state, cell_symbol(head_pos)};
          rule = rule_table[key];
          if (!rule.present) begin
            r.status = ST_NO_ENTRY;
          end else if (rule.move == MOVE_BAD) begin
            r.status = ST_BAD_MOVE;
          end else if (rule.move == MOVE_LEFT && head_pos == '0) begin
            r.status = ST_OFF_TAPE;
          end else if (rule.move == MOVE_RIGHT && int'(head_pos) + 1 >= TAPE_CELLS) begin
            r.status = ST_OFF_TAPE;
          end else begin
            new_head = head_pos;
            if (rule.move == MOVE_LEFT) new_head = head_pos - HEAD_BITS'(1);
            if (rule.move == MOVE_RIGHT) new_head = head_pos + HEAD_BITS'(1);
            tape_cells[head_pos] = '{written: 1'b1, sym: rule.sym};
            head_pos = new_head;
            if (rule.next != nop_state_q) machine_state = rule.next;
            r.symbol_out = rule.sym;
          end
        end
      end
      KIND_TAPE_RD: begin
        if (int'(it.position) < TAPE_CELLS) begin
          r.symbol_out = cell_symbol(it.position);
        end else begin
          r.status = ST_OFF_TAPE;
        end
      end
      default: ;
    endcase
    r.state_out = machine_state;
    r.head_out  = head_pos;
    r.halted    = (machine_state == halt_state_q);
    return r;
  endfunction

  task automatic check_field(string field, logic [HEAD_BITS-1:0] want,
                             logic [HEAD_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_machine();
      due_results.delete();
      fail_count_o = 0;
    end else begin
      if (result_valid_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing outstanding, expected none, actual %h",
                   $time, result_i);
          fail_count_o++;
        end else begin
          oldest = due_results.pop_front();
          check_field("status", HEAD_BITS'(oldest.status), HEAD_BITS'(result_i.status));
          check_field("state_out", HEAD_BITS'(oldest.state_out),
                      HEAD_BITS'(result_i.state_out));
          check_field("head_out", oldest.head_out, result_i.head_out);
          check_field("symbol_out", HEAD_BITS'(oldest.symbol_out),
                      HEAD_BITS'(result_i.symbol_out));
          check_field("halted", HEAD_BITS'(oldest.halted), HEAD_BITS'(result_i.halted));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_START_STATE: start_state_q = cfg_wdata_i[STATE_BITS-1:0];
          CFG_START_HEAD:  start_head_q  = cfg_wdata_i[HEAD_BITS-1:0];
          CFG_HALT_STATE:  halt_state_q  = cfg_wdata_i[STATE_BITS-1:0];
          CFG_NOP_STATE:   nop_state_q   = cfg_wdata_i[STATE_BITS-1:0];
          CFG_BLANK:       blank_q       = cfg_wdata_i[SYMBOL_BITS-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        due_results.push_back(predict_item(item_i));
      end
    end
    pending_o = due_results.size();
  end

endmodule

// ===== dv/turing_machine_stepper_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// turing_machine_stepper_tb
// drives the stepper with a directed walk through its refusal cases and
// edge moves, then with random rule tables and tapes under several register
// settings; prediction and comparison live in the checker beside the block
// ----------------------------------------------------------------------------
module turing_machine_stepper_tb;
  import tms_pkg::*;

  // kind codes the block ignores
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  // longest item latency, step through tape read, table read and write-back
  localparam int         LATENCY       = 3;
  localparam int         PHASES        = 7;
  localparam int         PHASE_ITEMS   = 120;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   start     = 1'b0;
  logic                   busy;
  item_t                  item      = '0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IW-1:0]      cfg_index = '0;
  logic [CFG_DW-1:0]      cfg_wdata = '0;
  logic                   result_valid;
  result_t                result;
  int                     fail_count;
  int                     pending;

  // copies of the current settings, used to steer the random programs
  logic [STATE_BITS-1:0]  prog_start_state;
  logic [HEAD_BITS-1:0]   prog_head;
  logic [STATE_BITS-1:0]  prog_halt;
  logic [STATE_BITS-1:0]  prog_nop;
  logic [SYMBOL_BITS-1:0] prog_blank;
  // states and symbols a random program works with
  logic [STATE_BITS-1:0]  prog_states [4];
  logic [SYMBOL_BITS-1:0] prog_syms [3];

  turing_machine_stepper u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  turing_machine_stepper_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_i (result_valid),
    .result_i       (result),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop, well beyond the clearing pass plus every item at its slowest
  initial begin
    #5_000_000;
    $display("turing_machine_stepper_tb failed");
    $finish;
  end

  function automatic item_t mk_item(logic [2:0] kind, logic [STATE_BITS-1:0] st,
                                    logic [SYMBOL_BITS-1:0] sym,
                                    logic [SYMBOL_BITS-1:0] wsym, logic [1:0] mv,
                                    logic [STATE_BITS-1:0] nxt,
                                    logic [HEAD_BITS-1:0] pos);
    item_t it;
    it.kind         = kind;
    it.state_in     = st;
    it.symbol_in    = sym;
    it.write_symbol = wsym;
    it.move_code    = mv;
    it.next_state   = nxt;
    it.position     = pos;
    return it;
  endfunction

  // fully random item, any kind code including the ignored ones
  function automatic item_t rand_item();
    return mk_item(3'($urandom_range(0, 7)), STATE_BITS'($urandom),
                   SYMBOL_BITS'($urandom), SYMBOL_BITS'($urandom),
                   2'($urandom_range(0, 3)), STATE_BITS'($urandom),
                   HEAD_BITS'($urandom));
  endfunction

  // rule for one key: mostly real moves, now and then a bad move code,
  // a jump to the halt state or the keep-state code
  function automatic item_t rule_item(logic [STATE_BITS-1:0] st,
                                      logic [SYMBOL_BITS-1:0] sym);
    logic [1:0]            mv;
    logic [STATE_BITS-1:0] nxt;
    int                    pick;
    mv   = ($urandom_range(0, 11) == 0) ? MOVE_BAD : 2'($urandom_range(0, 2));
    pick = $urandom_range(0, 9);
    if (pick == 0) nxt = prog_halt;
    else if (pick == 1) nxt = prog_nop;
    else nxt = prog_states[$urandom_range(0, 3)];
    return mk_item(KIND_TABLE_WR, st, sym, prog_syms[$urandom_range(0, 2)], mv, nxt,
                   HEAD_BITS'($urandom));
  endfunction

  // start stays high into the next item, so back-to-back transfers need no gap
  task automatic send_item(item_t it);
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // wait for every outstanding result, then let the block settle
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_config(logic [STATE_BITS-1:0] ss, logic [HEAD_BITS-1:0] sh,
                            logic [STATE_BITS-1:0] hs, logic [STATE_BITS-1:0] ns,
                            logic [SYMBOL_BITS-1:0] bl);
    write_cfg(CFG_START_STATE, CFG_DW'(ss));
    write_cfg(CFG_START_HEAD, sh);
    write_cfg(CFG_HALT_STATE, CFG_DW'(hs));
    write_cfg(CFG_NOP_STATE, CFG_DW'(ns));
    write_cfg(CFG_BLANK, CFG_DW'(bl));
    @(negedge clk);
    cfg_we <= 1'b0;
    prog_start_state = ss;
    prog_head        = sh;
    prog_halt        = hs;
    prog_nop         = ns;
    prog_blank       = bl;
  endtask

  // one random program: load a full rule table over a few states and symbols,
  // start it, then mostly step with restarts, rule rewrites, tape pokes and
  // reads near the start head and a share of noise
  task automatic run_program(int n_items, bit idle_on);
    item_t          it;
    int             sent;
    int             pick;
    prog_states[0] = prog_start_state;
    for (int i = 1; i < 4; i++) prog_states[i] = STATE_BITS'($urandom);
    prog_syms[0] = prog_blank;
    for (int i = 1; i < 3; i++) prog_syms[i] = SYMBOL_BITS'($urandom);
    for (int s = 0; s < 4; s++) begin
      for (int y = 0; y < 3; y++) send_item(rule_item(prog_states[s], prog_syms[y]));
    end
    send_item(mk_item(KIND_START, '0, '0, '0, MOVE_STAY, '0, '0));
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      it   = rand_item();
      if (pick < 55) begin
        it.kind = KIND_STEP;
      end else if (pick < 62) begin
        it.kind = KIND_START;
      end else if (pick < 72) begin
        it = rule_item(prog_states[$urandom_range(0, 3)], prog_syms[$urandom_range(0, 2)]);
      end else if (pick < 80) begin
        it.kind      = KIND_TAPE_WR;
        it.symbol_in = prog_syms[$urandom_range(0, 2)];
        it.position  = HEAD_BITS'(int'(prog_head) + $urandom_range(0, 48) - 24);
      end else if (pick < 88) begin
        it.kind     = KIND_TAPE_RD;
        it.position = HEAD_BITS'(int'(prog_head) + $urandom_range(0, 48) - 24);
      end
      send_item(it);
      if (it.kind <= KIND_TAPE_RD) sent++;
      if (idle_on && $urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 16));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    // clearing pass after reset keeps busy high
    @(negedge clk);
    while (busy) @(negedge clk);

    // low corner: head at cell 0, default halt and keep-state codes
    set_config('0, '0, 6'd63, 6'd62, '0);
    send_item(mk_item(KIND_TAPE_RD, '0, '0, '0, MOVE_STAY, '0, '0));
    // no rule loaded yet
    send_item(mk_item(KIND_STEP, '0, '0, '0, MOVE_STAY, '0, '0));
    send_item(mk_item(KIND_TABLE_WR, '0, '0, 4'd15, MOVE_LEFT, 6'd1, '0));
    send_item(mk_item(KIND_START, '0, '0, '0, MOVE_STAY, '0, '0));
    // left move from cell 0 falls off the tape
    send_item(mk_item(KIND_STEP, '0, '0, '0, MOVE_STAY, '0, '0));
    // stay with the keep-state code
    send_item(mk_item(KIND_TABLE_WR, '0, '0, 4'd9, MOVE_STAY, 6'd62, '0));
    send_item(mk_item(KIND_STEP, '0, '0, '0, MOVE_STAY, '0, '0));
    send_item(mk_item(KIND_TABLE_WR, '0, 4'd9, 4'd3, MOVE_BAD, 6'd2, '0));
    send_item(mk_item(KIND_STEP, '0, '0, '0, MOVE_STAY, '0, '0));
    // right move into the halt state, then a refused step
    send_item(mk_item(KIND_TABLE_WR, '0, 4'd9, 4'd15, MOVE_RIGHT, 6'd63, '0));
    send_item(mk_item(KIND_STEP, '0, '0, '0, MOVE_STAY, '0, '0));
    send_item(mk_item(KIND_STEP, '0, '0, '0, MOVE_STAY, '0, '0));
    send_item(mk_item(KIND_TAPE_RD, '0, '0, '0, MOVE_STAY, '0, '0));
    send_item(mk_item(KIND_TAPE_WR, '0, 4'd15, '0, MOVE_STAY, '0, 12'd4095));
    send_item(mk_item(KIND_TAPE_WR, '0, '0, '0, MOVE_STAY, '0, '0));
    send_item(mk_item(KIND_TABLE_WR, 6'd63, 4'd15, 4'd15, MOVE_BAD, 6'd63, 12'd4095));
    // ignored kinds, one with every other bit set and one with them all clear
    send_item(mk_item(KIND_SPARE_HI, 6'd63, 4'd15, 4'd15, MOVE_BAD, 6'd63, 12'd4095));
    send_item(mk_item(KIND_SPARE_LO, '0, '0, '0, MOVE_LEFT, '0, '0));
    drain();

    // high corner: head on the last cell, blank 15, halt at state 0
    set_config(6'd62, 12'd4095, '0, 6'd5, 4'd15);
    send_item(mk_item(KIND_START, '0, '0, '0, MOVE_STAY, '0, '0));
    send_item(mk_item(KIND_TABLE_WR, 6'd62, 4'd15, 4'd7, MOVE_RIGHT, 6'd5, '0));
    // right move from the last cell falls off the tape
    send_item(mk_item(KIND_STEP, '0, '0, '0, MOVE_STAY, '0, '0));
    send_item(mk_item(KIND_TABLE_WR, 6'd62, 4'd15, 4'd7, MOVE_LEFT, 6'd5, '0));
    send_item(mk_item(KIND_STEP, '0, '0, '0, MOVE_STAY, '0, '0));
    send_item(mk_item(KIND_TAPE_RD, '0, '0, '0, MOVE_STAY, '0, 12'd4095));
    send_item(mk_item(KIND_TAPE_RD, '0, '0, '0, MOVE_STAY, '0, 12'd4094));
    send_item(mk_item(KIND_TABLE_WR, 6'd62, 4'd15, 4'd2, MOVE_STAY, '0, '0));
    send_item(mk_item(KIND_STEP, '0, '0, '0, MOVE_STAY, '0, '0));
    drain();

    // random programs, first two at the register extremes, last one with
    // no idling at all
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        set_config('0, '0, 6'd63, '0, '0);
      end else if (p == 1) begin
        set_config(6'd63, 12'd4095, '0, 6'd63, 4'd15);
      end else begin
        set_config(STATE_BITS'($urandom), HEAD_BITS'($urandom), STATE_BITS'($urandom),
                   STATE_BITS'($urandom), SYMBOL_BITS'($urandom));
      end
      run_program(PHASE_ITEMS, (p < PHASES - 1) && ($urandom_range(0, 3) != 0));
      drain();
    end

    if (fail_count == 0) begin
      $display("turing_machine_stepper_tb passed");
    end else begin
      $display("turing_machine_stepper_tb failed");
    end
    $finish;
  end

endmodule
